// ----- rtl/core/brg_pkg.sv -----
package brg_pkg;

  localparam int unsigned MaxRows = 32;
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned CntW    = $clog2(MaxRows + 1);
  localparam int unsigned LimW    = 6;
  localparam int unsigned CoefW   = 32;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRow  = 3'b010,
    StExh  = 3'b100
  } state_e;

  // Control handed from the sequencer to the datapath once per emitted result.
  typedef struct packed {
    logic            step;
    logic            exh;
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
    logic            last;
  } ctl_t;

endpackage

// ----- rtl/core/brg_cell.sv -----
module brg_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      tail_i,
  input  logic [brg_pkg::CoefW-1:0] nbr_i,
  input  logic [brg_pkg::CoefW-1:0] fresh_i,
  output logic [brg_pkg::CoefW-1:0] value_o
);

  logic [brg_pkg::CoefW-1:0] value_q;
  logic [brg_pkg::CoefW-1:0] value_d;

  // The tail cell of the active ring takes the new entry; the others take their right neighbor.
  assign value_d = tail_i ? fresh_i : nbr_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// ----- rtl/core/brg_seq.sv -----
module brg_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     restart_i,
  input  logic                     out_free_i,
  input  logic [brg_pkg::LimW-1:0] limit_i,
  output logic                     in_stall_o,
  output brg_pkg::ctl_t            ctl_o
);

  brg_pkg::state_e              state_q, state_d;
  logic [brg_pkg::CntW-1:0]     next_row_q, next_row_d;
  logic [brg_pkg::RowW-1:0]     row_q, row_d;
  logic [brg_pkg::RowW-1:0]     col_q, col_d;
  logic [brg_pkg::CntW-1:0]     start_row;
  logic [brg_pkg::CntW-1:0]     lim_eff;
  logic                         accept;
  logic                         step;
  logic                         at_end;

  assign lim_eff = (limit_i > brg_pkg::LimW'(brg_pkg::MaxRows))
                 ? brg_pkg::CntW'(brg_pkg::MaxRows)
                 : brg_pkg::CntW'(limit_i);

  assign in_stall_o = (state_q != brg_pkg::StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign start_row  = restart_i ? '0 : next_row_q;
  assign step       = (state_q != brg_pkg::StIdle) && out_free_i;
  assign at_end     = (col_q == row_q);

  always_comb begin
    state_d    = state_q;
    next_row_d = next_row_q;
    row_d      = row_q;
    col_d      = col_q;
    unique case (state_q)
      brg_pkg::StIdle: begin
        if (accept) begin
          next_row_d = start_row;
          row_d      = start_row[brg_pkg::RowW-1:0];
          col_d      = '0;
          state_d    = (start_row >= lim_eff) ? brg_pkg::StExh : brg_pkg::StRow;
        end
      end
      brg_pkg::StRow: begin
        if (step) begin
          col_d = col_q + brg_pkg::RowW'(1);
          if (at_end) begin
            next_row_d = brg_pkg::CntW'(row_q) + brg_pkg::CntW'(1);
            state_d    = brg_pkg::StIdle;
          end
        end
      end
      brg_pkg::StExh: begin
        if (step) begin
          state_d = brg_pkg::StIdle;
        end
      end
      default: begin
        state_d = brg_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= brg_pkg::StIdle;
      next_row_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      state_q    <= state_d;
      next_row_q <= next_row_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  assign ctl_o.step = step;
  assign ctl_o.exh  = (state_q == brg_pkg::StExh);
  assign ctl_o.row  = row_q;
  assign ctl_o.col  = col_q;
  assign ctl_o.last = (state_q == brg_pkg::StExh) || at_end;

endmodule

// ----- rtl/core/binomial_row_generator_top.sv -----
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | restart_i
// out     | output    | out_valid_o / out_stall_i| row_index_o, column_index_o, coefficient_o,
//         |           |                        | last_of_row_o, exhausted_o
// cfg     | input     | cfg_we_i               | cfg_data_i (row limit)
//
// Row r is taken while idle, then its r+1 entries follow one per cycle while the output is
// free. An exhausted request yields one result. The row lives in a chain of 32 cells that
// rotates one place per emitted entry, and the single adder at the chain head sets the pace.
// No clearing pass follows reset; the first request may arrive right after it.
// A stall on the output holds the chain; a new request is taken while a result still waits.
module binomial_row_generator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [brg_pkg::LimW-1:0]         cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [4:0]                       row_index_o,
  output logic [4:0]                       column_index_o,
  output logic [31:0]                      coefficient_o,
  output logic                             last_of_row_o,
  output logic                             exhausted_o
);

  logic [brg_pkg::LimW-1:0]  limit_q;
  brg_pkg::ctl_t             ctl;
  logic                      out_free;
  logic [brg_pkg::CoefW-1:0] cell_val [brg_pkg::MaxRows];
  logic [brg_pkg::CoefW-1:0] head;
  logic [brg_pkg::CoefW-1:0] prev_q;
  logic [brg_pkg::CoefW-1:0] fresh;
  logic                      out_valid_q;
  logic [brg_pkg::RowW-1:0]  row_q;
  logic [brg_pkg::RowW-1:0]  col_q;
  logic [brg_pkg::CoefW-1:0] coef_q;
  logic                      last_q;
  logic                      exh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= brg_pkg::LimW'(brg_pkg::MaxRows);
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  brg_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .out_free_i (out_free),
    .limit_i    (limit_q),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  // Cell 0 holds the old row's entry for each column it has; prev_q holds the one before it.
  assign head  = cell_val[0];
  assign fresh = ((ctl.col == '0) || (ctl.col == ctl.row)) ? brg_pkg::CoefW'(1)
               : prev_q + head;

  for (genvar k = 0; k < brg_pkg::MaxRows; k++) begin : g_cell
    logic cell_en;
    logic cell_tail;
    assign cell_en   = ctl.step && !ctl.exh && (brg_pkg::RowW'(k) <= ctl.row);
    assign cell_tail = (brg_pkg::RowW'(k) == ctl.row);
    brg_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (cell_en),
      .tail_i  (cell_tail),
      .nbr_i   (cell_val[(k + 1) % brg_pkg::MaxRows]),
      .fresh_i (fresh),
      .value_o (cell_val[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ctl.step && !ctl.exh) begin
      prev_q <= head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.step) begin
      row_q  <= ctl.exh ? '0 : ctl.row;
      col_q  <= ctl.exh ? '0 : ctl.col;
      coef_q <= ctl.exh ? '0 : fresh;
      last_q <= ctl.last;
      exh_q  <= ctl.exh;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_index_o    = row_q;
  assign column_index_o = col_q;
  assign coefficient_o  = coef_q;
  assign last_of_row_o  = last_q;
  assign exhausted_o    = exh_q;

endmodule

// ----- rtl/core/brg_checker.sv -----
module brg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  row_index_o,
  input logic [4:0]  column_index_o,
  input logic [31:0] coefficient_o,
  input logic        last_of_row_o,
  input logic        exhausted_o
);

  // An exhausted result is the only result of its request and carries no entry.
  a_exh_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && exhausted_o) |-> (last_of_row_o && (coefficient_o == 32'd0)))
    else $error("exhausted result malformed");

  // Both ends of every row are one.
  a_row_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !exhausted_o &&
     ((column_index_o == 5'd0) || (column_index_o == row_index_o)))
      |-> (coefficient_o == 32'd1))
    else $error("row end is not one");

  // The entry at the row's own index closes the request.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !exhausted_o) |-> (last_of_row_o == (column_index_o == row_index_o)))
    else $error("last_of_row misplaced");

  // A taken request keeps the input stalled while its results are produced.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(coefficient_o)))
    else $error("stalled result changed");

endmodule

bind binomial_row_generator_top brg_checker u_brg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .row_index_o    (row_index_o),
  .column_index_o (column_index_o),
  .coefficient_o  (coefficient_o),
  .last_of_row_o  (last_of_row_o),
  .exhausted_o    (exhausted_o)
);

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [brg_pkg::RowW-1:0]  row;
    logic [brg_pkg::RowW-1:0]  col;
    logic [brg_pkg::CoefW-1:0] coef;
    logic                      last;
    logic                      exh;
  } row_entry_t;

  // Keeps its own copy of the previous triangle row and queues the entries
  // that each accepted request must produce.
  class row_predictor;
    logic [brg_pkg::CoefW-1:0] last_row [brg_pkg::MaxRows];
    int unsigned next_row;
    int unsigned row_limit;
    row_entry_t  expected_entries[$];
    int          errors;
    int          checked;
    int          exhausted_seen;
    int          deepest;

    function new();
      next_row  = 0;
      row_limit = 32;
      deepest   = 0;
    endfunction

    function void set_limit(logic [brg_pkg::LimW-1:0] value);
      row_limit = value;
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction

    function void note_request(bit restart);
      logic [brg_pkg::CoefW-1:0] fresh [brg_pkg::MaxRows];
      int unsigned               eff;
      int unsigned               r;
      row_entry_t                e;
      eff = row_limit;
      if (eff > brg_pkg::MaxRows) begin
        eff = brg_pkg::MaxRows;
      end
      if (restart) begin
        next_row = 0;
      end
      if (next_row >= eff) begin
        e.row  = '0;
        e.col  = '0;
        e.coef = '0;
        e.last = 1'b1;
        e.exh  = 1'b1;
        expected_entries = {expected_entries, e};
        return;
      end
      r = next_row;
      for (int unsigned j = 0; j <= r; j++) begin
        if (j == 0 || j == r) begin
          fresh[j] = 1;
        end else begin
          fresh[j] = last_row[j-1] + last_row[j];
        end
      end
      for (int unsigned j = 0; j <= r; j++) begin
        last_row[j] = fresh[j];
        e.row  = r[brg_pkg::RowW-1:0];
        e.col  = j[brg_pkg::RowW-1:0];
        e.coef = fresh[j];
        e.last = (j == r);
        e.exh  = 1'b0;
        expected_entries = {expected_entries, e};
      end
      next_row = r + 1;
      if (r > deepest) begin
        deepest = r;
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [4:0] row, logic [4:0] col, logic [31:0] coef,
                               logic last, logic exh);
      row_entry_t want;
      if (expected_entries.size() == 0) begin
        $error("result row %0d column %0d arrived with no request pending", row, col);
        errors++;
        return;
      end
      want = expected_entries.pop_front();
      compare("row_index", want.row, row);
      compare("column_index", want.col, col);
      compare("coefficient", want.coef, coef);
      compare("last_of_row", want.last, last);
      compare("exhausted", want.exh, exh);
      checked++;
      if (want.exh) begin
        exhausted_seen++;
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [brg_pkg::LimW-1:0]   cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic                       restart_i   = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [4:0]                 row_index_o;
  logic [4:0]                 column_index_o;
  logic [31:0]                coefficient_o;
  logic                       last_of_row_o;
  logic                       exhausted_o;

  row_predictor sb;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_req       = 0;
  int           hold_len       = 0;
  int           hold_seen      = 0;
  int           hold_left      = 0;
  int           requests_sent  = 0;
  int           limits_set     = 0;

  binomial_row_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .coefficient_o  (coefficient_o),
    .last_of_row_o  (last_of_row_o),
    .exhausted_o    (exhausted_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // Output side: checks every accepted result, then decides the stall for
  // the next cycle. A long hold-off request overrides the random stall.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result(row_index_o, column_index_o, coefficient_o, last_of_row_o,
                      exhausted_o);
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(input bit restart);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(restart);
    requests_sent++;
  endtask

  // Lets every outstanding result drain, then a margin beyond the longest row.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [brg_pkg::LimW-1:0] value);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(value);
    limits_set++;
  endtask

  task automatic hold_output(input int cycles);
    hold_len <= cycles;
    hold_req <= hold_req + 1;
  endtask

  // Mostly long runs of plain advances so the deep rows and the limit are
  // reached; short noisy bursts restart often.
  task automatic run_phase(input int n_items, input int send_pct, input int recv_pct,
                           input logic [brg_pkg::LimW-1:0] lim, input bit pressure);
    bit noisy;
    noisy = 1'b0;
    write_limit(lim);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    if (pressure) begin
      hold_output(400);
    end
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        noisy = ($urandom_range(4) == 0);
      end
      if (pressure && i == n_items / 2) begin
        hold_output(300);
      end
      send_request($urandom_range(99) < (noisy ? 35 : 3));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limit of 32 first, then a restart in the middle of a sequence.
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);

    // A zero limit reports exhausted on every request, restart or not.
    write_limit(6'd0);
    send_request(1'b0);
    send_request(1'b1);

    // Reach a small limit, then raise it and resume where the rows stopped.
    write_limit(6'd2);
    repeat (3) send_request(1'b0);
    write_limit(6'd4);
    repeat (3) send_request(1'b0);

    write_limit(6'd1);
    send_request(1'b1);
    send_request(1'b0);

    // A limit above the row capacity saturates.
    write_limit(6'd63);
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    run_phase(90, 0, 0, 6'd63, 1'b0);
    run_phase(90, 80, 0, 6'd32, 1'b0);
    run_phase(90, 0, 80, 6'($urandom_range(1, 40)), 1'b1);
    run_phase(90, 36, 36, 6'($urandom_range(8, 31)), 1'b0);
    run_phase(90, 0, 0, 6'd32, 1'b1);
    settle();

    $display("Sent %0d requests under %0d row limits; %0d results checked, %0d exhausted.",
             requests_sent, limits_set, sb.checked, sb.exhausted_seen);
    $display("Deepest row produced: %0d.", sb.deepest);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/brg_pkg.sv
rtl/core/brg_cell.sv
rtl/core/brg_seq.sv
rtl/core/binomial_row_generator_top.sv
rtl/core/brg_checker.sv
sim/tb.sv
